/* hdl/srt_pkg.sv */
`default_nettype none

package srt_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int SALES_W = 24;
  localparam int REV_W   = 64;
  localparam int POS_W   = 6;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [SALES_W-1:0] sales;
    logic [REV_W-1:0]   revenue;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

/* hdl/srt_in_if.sv */
`default_nettype none

interface srt_in_if
  import srt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [SALES_W-1:0] sales_count;
  logic [REV_W-1:0]   revenue_bits;
  logic               final_record;

  modport source (output valid, year, month, sales_count, revenue_bits, final_record,
                  input ready);
  modport sink   (input valid, year, month, sales_count, revenue_bits, final_record,
                  output ready);
endinterface

`default_nettype wire

/* hdl/srt_out_if.sv */
`default_nettype none

interface srt_out_if
  import srt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [SALES_W-1:0] out_sales_count;
  logic [REV_W-1:0]   out_revenue_bits;
  logic [POS_W-1:0]   position;
  logic               run_end;
  logic               dropped;

  modport source (output valid, out_year, out_month, out_sales_count, out_revenue_bits,
                         position, run_end, dropped,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_sales_count, out_revenue_bits,
                        position, run_end, dropped,
                  output ready);
endinterface

`default_nettype wire

/* hdl/srt_ram.sv */
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/sort_records_by_year_month.sv */
`default_nettype none

// Record sorter: loads one word per cycle while ready.
// After the final word, the batch is sorted with one compare-exchange per cycle
// through a single-port-read record RAM; then the sorted records are emitted in
// order, each word held until the receiver takes it.
// Reset (rst, synchronous, active high) empties the batch and drops the output valid.
// The record RAM itself is not cleared; only entries of the current batch are read.

module sort_records_by_year_month
  import srt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  srt_in_if.sink   rec_in,
  srt_out_if.source rec_out
);

  // The sequencer keeps record i in a register (cur) while j walks the rest of
  // the batch. On an exchange cur goes to slot j and record j becomes the new
  // cur; slot i is written once at the end of the inner pass. This gives the
  // same result as swapping in place at every step.
  typedef enum logic [2:0] {
    LOAD,    // accepting input words
    RD_I,    // fetch record 0 to start the first pass
    CUR,     // latch record i, fetch record i+1
    CMP,     // compare cur against record j, exchange if cur is greater
    WB,      // write cur back to slot i, fetch record i+1
    E_RD,    // fetch first record for emission
    E_WAIT,  // load the output register from the RAM
    E_HOLD   // present the word until it is taken
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] k_idx;
  rec_t             cur;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [REC_W-1:0] rd_raw;
  rec_t             rd_rec;

  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] last_idx;
  logic             greater;

  assign rd_rec   = rec_t'(rd_raw);
  assign accept   = rec_in.valid && rec_in.ready;
  assign room     = (count < CNT_W'(MAX_RECORDS));
  assign count_next = room ? count + CNT_W'(1) : count;
  assign last_idx = IDX_W'(count - CNT_W'(1));

  // Key order: year first, then month; the concatenation compares exactly so.
  assign greater = {cur.year, cur.month} > {rd_rec.year, rd_rec.month};

  assign rec_in.ready = (state == LOAD);

  srt_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // RAM port control. Outside LOAD, a write and a read in one cycle always hit
  // different slots; during LOAD the read data is never used.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_idx;
    wr_data = cur;
    rd_addr = i_idx;
    unique case (state)
      LOAD: begin
        wr_en   = accept && room;
        wr_addr = count[IDX_W-1:0];
        wr_data = '{year:    rec_in.year,
                    month:   rec_in.month,
                    sales:   rec_in.sales_count,
                    revenue: rec_in.revenue_bits};
      end
      RD_I: begin
        rd_addr = i_idx;
      end
      CUR: begin
        rd_addr = i_idx + IDX_W'(1);
      end
      CMP: begin
        wr_en   = greater;
        wr_addr = j_idx;
        rd_addr = j_idx + IDX_W'(1);
      end
      WB: begin
        wr_en   = 1'b1;
        wr_addr = i_idx;
        rd_addr = i_idx + IDX_W'(1);
      end
      E_RD: begin
        rd_addr = k_idx;
      end
      E_WAIT: begin
        rd_addr = k_idx;
      end
      E_HOLD: begin
        rd_addr = k_idx + IDX_W'(1);
      end
      default: begin
        rd_addr = i_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      count         <= '0;
      overflow      <= 1'b0;
      i_idx         <= '0;
      j_idx         <= '0;
      k_idx         <= '0;
      rec_out.valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (accept) begin
            count <= count_next;
            if (!room) begin
              overflow <= 1'b1;
            end
            if (rec_in.final_record) begin
              i_idx <= '0;
              k_idx <= '0;
              // A single record needs no sorting.
              if (count_next > CNT_W'(1)) begin
                state <= RD_I;
              end else begin
                state <= E_RD;
              end
            end
          end
        end
        RD_I: begin
          state <= CUR;
        end
        CUR: begin
          cur   <= rd_rec;
          j_idx <= i_idx + IDX_W'(1);
          state <= CMP;
        end
        CMP: begin
          if (greater) begin
            cur <= rd_rec;
          end
          if (j_idx == last_idx) begin
            state <= WB;
          end else begin
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        WB: begin
          i_idx <= i_idx + IDX_W'(1);
          if (i_idx + IDX_W'(1) == last_idx) begin
            state <= E_RD;
          end else begin
            state <= CUR;
          end
        end
        E_RD: begin
          state <= E_WAIT;
        end
        E_WAIT: begin
          rec_out.valid            <= 1'b1;
          rec_out.out_year         <= rd_rec.year;
          rec_out.out_month        <= rd_rec.month;
          rec_out.out_sales_count  <= rd_rec.sales;
          rec_out.out_revenue_bits <= rd_rec.revenue;
          rec_out.position         <= POS_W'(k_idx);
          rec_out.run_end          <= (k_idx == last_idx);
          rec_out.dropped          <= overflow;
          state                    <= E_HOLD;
        end
        E_HOLD: begin
          if (rec_out.ready) begin
            rec_out.valid <= 1'b0;
            if (k_idx == last_idx) begin
              // Batch done: empty the store for the next one.
              count    <= '0;
              overflow <= 1'b0;
              state    <= LOAD;
            end else begin
              k_idx <= k_idx + IDX_W'(1);
              state <= E_WAIT;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sort_records_by_year_month_tb.sv */
`timescale 1ns / 100ps

module sort_records_by_year_month_tb;
  import srt_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  // A full batch takes the longest to sort and there are only a handful of
  // them. Even with the receiver stalling hard, the whole run stays far below
  // this limit.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int WORDS_PER_PHASE = 95;
  // This is the quiet time after the last sorted word of a phase. It catches
  // any word the block emits beyond what the batch called for.
  localparam int SETTLE_CYCLES   = 40;
  localparam int N_DIRECTED      = 19;

  // This is one word of the sorted output stream, as the receiver expects it.
  typedef struct packed {
    rec_t             rec;
    logic [POS_W-1:0] position;
    logic             run_end;
    logic             dropped;
  } sorted_word_t;

  // This is one row of the directed table. Where typed is set, the row is a
  // one-record batch, and typed_out is the single word it must produce.
  typedef struct packed {
    rec_t         rec;
    logic         last;
    logic         typed;
    sorted_word_t typed_out;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  sort_records_by_year_month u_dut (
    .clk    (clk),
    .rst    (rst),
    .rec_in (in_ch),
    .rec_out(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Directed rows come first. The one-record batches at the head are simple
  // enough to write their output by hand. The multi-record batches cover these
  // cases: a batch in strictly descending order, a batch with repeated keys
  // (whose order the exchange sort decides), a batch of alternating bit
  // patterns that share years, and a batch that is already sorted.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{14'd0, 4'd1, 24'd0, 64'd0}, 1'b1, 1'b1,
      '{'{14'd0, 4'd1, 24'd0, 64'd0}, 6'd0, 1'b1, 1'b0}},
    '{'{14'h3FFF, 4'hF, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, 1'b1,
      '{'{14'h3FFF, 4'hF, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 6'd0, 1'b1, 1'b0}},
    '{'{14'd9999, 4'd12, 24'h12_3456, 64'h0123_4567_89AB_CDEF}, 1'b1, 1'b1,
      '{'{14'd9999, 4'd12, 24'h12_3456, 64'h0123_4567_89AB_CDEF}, 6'd0, 1'b1, 1'b0}},
    '{'{14'd1, 4'd0, 24'd7, 64'h8000_0000_0000_0001}, 1'b1, 1'b1,
      '{'{14'd1, 4'd0, 24'd7, 64'h8000_0000_0000_0001}, 6'd0, 1'b1, 1'b0}},
    '{'{14'd9999, 4'd12, 24'd1, 64'd101}, 1'b0, 1'b0, '0},
    '{'{14'd2024, 4'd6, 24'd2, 64'd102}, 1'b0, 1'b0, '0},
    '{'{14'd2024, 4'd5, 24'd3, 64'd103}, 1'b0, 1'b0, '0},
    '{'{14'd0, 4'd1, 24'd4, 64'd104}, 1'b1, 1'b0, '0},
    '{'{14'd2000, 4'd3, 24'd10, 64'd110}, 1'b0, 1'b0, '0},
    '{'{14'd1999, 4'd12, 24'd11, 64'd111}, 1'b0, 1'b0, '0},
    '{'{14'd2000, 4'd3, 24'd12, 64'd112}, 1'b0, 1'b0, '0},
    '{'{14'd2000, 4'd3, 24'd13, 64'd113}, 1'b0, 1'b0, '0},
    '{'{14'd1999, 4'd1, 24'd14, 64'd114}, 1'b1, 1'b0, '0},
    '{'{14'h2AAA, 4'hA, 24'hAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, 1'b0, '0},
    '{'{14'h1555, 4'h5, 24'h55_5555, 64'h5555_5555_5555_5555}, 1'b0, 1'b0, '0},
    '{'{14'h2AAA, 4'h5, 24'h55_AAAA, 64'h5555_AAAA_5555_AAAA}, 1'b0, 1'b0, '0},
    '{'{14'h1555, 4'hA, 24'hAA_5555, 64'hAAAA_5555_AAAA_5555}, 1'b1, 1'b0, '0},
    '{'{14'd1, 4'd1, 24'd20, 64'd120}, 1'b0, 1'b0, '0},
    '{'{14'd1, 4'd2, 24'd21, 64'd121}, 1'b1, 1'b0, '0}
  };

  // These knobs set how often each side idles. When quiet is set, both sides
  // run flat out for a stretch. That way the block also sees long runs with no
  // gaps, even in the phases that idle a lot.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit quiet          = 1'b0;

  int cycle_count      = 0;
  int mismatch_count   = 0;
  int words_sent       = 0;
  int words_checked    = 0;
  int batches_done     = 0;
  int overflow_batches = 0;

  // The predictor keeps its own copy of the batch being loaded. It sorts that
  // copy when the final word is accepted.
  rec_t         batch_store [MAX_RECORDS];
  int           batch_fill     = 0;
  bit           batch_overflow = 1'b0;
  sorted_word_t sorted_expect [$];

  // This function takes one accepted word. It stores the record if there is
  // room and marks the batch as overflowed if not. On the final word it runs
  // the same exchange sort as the block and queues the sorted words. Comparing
  // the concatenation {year, month} gives exactly the year-then-month order.
  function automatic void absorb_word(rec_t r, bit last);
    rec_t         held;
    sorted_word_t w;
    if (batch_fill < MAX_RECORDS) begin
      batch_store[batch_fill] = r;
      batch_fill++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < batch_fill; i++) begin
        for (int j = i + 1; j < batch_fill; j++) begin
          if ({batch_store[i].year, batch_store[i].month} >
              {batch_store[j].year, batch_store[j].month}) begin
            held           = batch_store[i];
            batch_store[i] = batch_store[j];
            batch_store[j] = held;
          end
        end
      end
      for (int i = 0; i < batch_fill; i++) begin
        w.rec      = batch_store[i];
        w.position = POS_W'(i);
        w.run_end  = (i == batch_fill - 1);
        w.dropped  = batch_overflow;
        sorted_expect.push_back(w);
      end
      if (batch_overflow) begin
        overflow_batches++;
      end
      batches_done++;
      batch_fill     = 0;
      batch_overflow = 1'b0;
    end
  endfunction

  // Years are drawn from four kinds of value. A small cluster makes equal
  // keys likely. The other three are the legal range, the raw 14-bit field,
  // and its two extremes. Most months are legal, but all 16 codes occur.
  function automatic rec_t random_record();
    rec_t r;
    case ($urandom_range(0, 3))
      0: begin
        r.year = YEAR_W'(2000 + $urandom_range(0, 3));
      end
      1: begin
        r.year = YEAR_W'($urandom_range(0, 9999));
      end
      2: begin
        r.year = YEAR_W'($urandom);
      end
      default: begin
        r.year = $urandom_range(0, 1) ? {YEAR_W{1'b1}} : {YEAR_W{1'b0}};
      end
    endcase
    r.month   = ($urandom_range(0, 4) != 0) ? MONTH_W'($urandom_range(1, 12))
                                            : MONTH_W'($urandom);
    r.sales   = SALES_W'($urandom);
    r.revenue = {$urandom, $urandom};
    return r;
  endfunction

  // Most batches are short, which keeps the quadratic sort time low. About one
  // in twelve comes near the store's capacity; most of those fill it or run past it.
  function automatic int random_batch_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return $urandom_range(1, 6);
    end else if (pick < 92) begin
      return $urandom_range(7, 20);
    end
    return $urandom_range(60, MAX_RECORDS + 6);
  endfunction

  // This task offers one word and returns at the edge where it is accepted.
  // The random idle cycles come before the word is raised. Once raised, valid
  // stays high until the handshake completes.
  task automatic send_word(rec_t r, bit last);
    if (!quiet) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.year         <= r.year;
    in_ch.month        <= r.month;
    in_ch.sales_count  <= r.sales;
    in_ch.revenue_bits <= r.revenue;
    in_ch.final_record <= last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  // Here the sender holds off until every queued sorted word has come back.
  // It then lets the settle time pass before the next phase starts.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sorted_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_sorted_word();
    sorted_word_t want;
    if (sorted_expect.size() == 0) begin
      $error("sorted word at position %0d arrived with nothing awaited", out_ch.position);
      mismatch_count++;
    end else begin
      want = sorted_expect.pop_front();
      check_field("out_year", 64'(want.rec.year), 64'(out_ch.out_year));
      check_field("out_month", 64'(want.rec.month), 64'(out_ch.out_month));
      check_field("out_sales_count", 64'(want.rec.sales), 64'(out_ch.out_sales_count));
      check_field("out_revenue_bits", want.rec.revenue, out_ch.out_revenue_bits);
      check_field("position", 64'(want.position), 64'(out_ch.position));
      check_field("run_end", 64'(want.run_end), 64'(out_ch.run_end));
      check_field("dropped", 64'(want.dropped), 64'(out_ch.dropped));
      words_checked++;
    end
  endtask

  // This is the receiver. At each edge it checks the word on offer if it was
  // taken, then chooses whether to stall on the next cycle.
  initial begin : sorted_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        check_sorted_word();
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // The watchdog ends a run that hangs, whether the block stops emitting or
  // stops accepting words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d sorted words still awaited",
               cycle_count, sorted_expect.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int forced_size;
    int batch_size;
    int phase_words;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.year         = '0;
    in_ch.month        = '0;
    in_ch.sales_count  = '0;
    in_ch.revenue_bits = '0;
    in_ch.final_record = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side. Each typed-in row is a
    // whole batch, so the predictor holds nothing when that row is sent, and
    // the hand-written word stands in for a predicted one.
    for (int k = 0; k < N_DIRECTED; k++) begin
      send_word(directed_rows[k].rec, directed_rows[k].last);
      if (directed_rows[k].typed) begin
        sorted_expect.push_back(directed_rows[k].typed_out);
        batches_done++;
      end else begin
        absorb_word(directed_rows[k].rec, directed_rows[k].last);
      end
    end
    drain();

    // Random part, in four phases: no idling, sender idle, receiver stalling,
    // and both sides idling. Each of the first three phases opens with one batch
    // at the capacity edge. Phase zero fills the store exactly. In phase one the
    // final word itself is dropped. In phase two several words are dropped.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          forced_size    = MAX_RECORDS;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
          forced_size    = MAX_RECORDS + 1;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
          forced_size    = MAX_RECORDS + 3;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
          forced_size    = 0;
        end
      endcase
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        batch_size  = (forced_size != 0) ? forced_size : random_batch_size();
        forced_size = 0;
        quiet       = (phase != 0) && ($urandom_range(0, 6) == 0);
        for (int k = 0; k < batch_size; k++) begin
          rec_t r;
          r = random_record();
          send_word(r, k == batch_size - 1);
          absorb_word(r, k == batch_size - 1);
        end
        phase_words += batch_size;
      end
      quiet = 1'b0;
      drain();
    end

    $display("%0d words sent in %0d batches, %0d of them over capacity",
             words_sent, batches_done, overflow_batches);
    $display("%0d sorted words checked under four idling phases, %0d mismatches",
             words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
